// ===== src/mbfe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the mbox From-line escaper.
package mbfe_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [2:0] PFX_LEN  = 3'd5;
	localparam logic [2:0] PFX_LAST = 3'd4;

	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_EOM  = 1'b1;

	// One output run: an optional '>', the first cnt bytes of "From ", then an optional tail.
	typedef struct packed {
		logic       gt;
		logic [2:0] cnt;
		logic       has_tail;
		logic [7:0] tail;
		logic       done;
	} cmd_t;

	function automatic logic [7:0] pfx_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0:    b = CH_F;
			3'd1:    b = CH_R;
			3'd2:    b = CH_O;
			3'd3:    b = CH_M;
			3'd4:    b = CH_SPACE;
			default: b = CH_SPACE;
		endcase
		return b;
	endfunction

endpackage

// ===== src/mbfe_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for message items and mailbox bytes.
interface mbfe_msg_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source(output valid, kind, data_byte, input ready);
	modport sink(input valid, kind, data_byte, output ready);
endinterface

interface mbfe_mbox_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       message_done;

	modport source(output valid, out_byte, last_of_run, message_done, input ready);
	modport sink(input valid, out_byte, last_of_run, message_done, output ready);
endinterface

// ===== src/mbox_from_line_escaper.sv =====
`timescale 1ns / 1ps
// Top level of the mbox From-line escaper.
// The block accepts one message item per cycle as long as its run queue has room
// (QUEUE_DEPTH runs, four by default). Bytes held back as a possible "From " prefix
// produce nothing and push no run, as does an end of message in copy mode with no
// bytes held. Every other item produces a run of one to six bytes, and the back-end
// sequencer emits one byte per cycle from the output register while the receiver is
// ready, so the output side sets the pace and plain text passes at one byte per
// cycle. A result passes through the run queue and the output register before it is
// seen. escape_enable is written through cfg_wr_en and cfg_wr_data and resets to 1;
// the user must change it only while the block is idle, which the block itself does
// not enforce.
module mbox_from_line_escaper #(
	parameter int QUEUE_DEPTH = mbfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	mbfe_msg_if.sink    msg,
	mbfe_mbox_if.source mbox
);
	import mbfe_pkg::*;

	cmd_t wr_cmd;
	cmd_t head;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	mbfe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.msg         (msg),
		.q_full      (q_full),
		.push        (push),
		.cmd         (wr_cmd)
	);

	mbfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.head   (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	mbfe_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (q_empty),
		.pop    (pop),
		.mbox   (mbox)
	);

endmodule

// ===== src/mbfe_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts message items, tracks the line-start match and issues output runs.
module mbfe_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic          cfg_wr_data,
	mbfe_msg_if.sink      msg,
	input  logic          q_full,
	output logic          push,
	output mbfe_pkg::cmd_t cmd
);
	import mbfe_pkg::*;

	logic       esc_q;
	logic       als_q;
	logic [2:0] pm_q;
	logic       accept;
	logic       match;
	logic       need_push;
	logic       als_d;
	logic [2:0] pm_d;

	assign msg.ready = !q_full;
	assign accept    = msg.valid && msg.ready;
	assign match     = esc_q && (msg.kind == KIND_DATA) && als_q
		&& (msg.data_byte == pfx_byte(pm_q));

	always_comb begin
		cmd.gt       = 1'b0;
		cmd.cnt      = pm_q;
		cmd.has_tail = 1'b1;
		cmd.tail     = msg.data_byte;
		cmd.done     = 1'b0;
		need_push    = 1'b1;
		als_d        = (msg.data_byte == CH_NL);
		pm_d         = 3'd0;
		if (msg.kind == KIND_EOM) begin
			cmd.has_tail = esc_q;
			cmd.tail     = CH_NL;
			cmd.done     = 1'b1;
			need_push    = esc_q || (pm_q != 3'd0);
			als_d        = 1'b1;
		end else if (match) begin
			if (pm_q == PFX_LAST) begin
				cmd.gt       = 1'b1;
				cmd.cnt      = PFX_LEN;
				cmd.has_tail = 1'b0;
				als_d        = 1'b0;
			end else begin
				need_push = 1'b0;
				als_d     = 1'b1;
				pm_d      = pm_q + 3'd1;
			end
		end
	end

	assign push = accept && need_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= 1'b1;
			als_q <= 1'b1;
			pm_q  <= 3'd0;
		end else begin
			if (cfg_wr_en) begin
				esc_q <= cfg_wr_data;
			end
			if (accept) begin
				als_q <= als_d;
				pm_q  <= pm_d;
			end
		end
	end

endmodule

// ===== src/mbfe_queue.sv =====
`timescale 1ns / 1ps
// Short run queue between the front end and the back end.
module mbfe_queue #(
	parameter int DEPTH = mbfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mbfe_pkg::cmd_t wr_cmd,
	input  logic           pop,
	output mbfe_pkg::cmd_t head,
	output logic           full,
	output logic           empty
);
	import mbfe_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== src/mbfe_back.sv =====
`timescale 1ns / 1ps
// Back end: steps through each queued run one byte a cycle into the output register while the output is not stalled.
module mbfe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  mbfe_pkg::cmd_t head,
	input  logic           empty,
	output logic           pop,
	mbfe_mbox_if.source    mbox
);
	import mbfe_pkg::*;

	logic [2:0] pos_q;
	logic       ov_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       done_q;
	logic       adv;
	logic [2:0] len;
	logic [2:0] k;
	logic       is_last;
	logic [7:0] cur_byte;

	assign adv     = !empty && (!ov_q || mbox.ready);
	assign len     = {2'b00, head.gt} + head.cnt + {2'b00, head.has_tail};
	assign k       = pos_q - {2'b00, head.gt};
	assign is_last = (pos_q == len - 3'd1);
	assign pop     = adv && is_last;

	always_comb begin
		if (head.gt && (pos_q == 3'd0)) begin
			cur_byte = CH_GT;
		end else if (k < head.cnt) begin
			cur_byte = pfx_byte(k);
		end else begin
			cur_byte = head.tail;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q <= cur_byte;
			last_q <= is_last;
			done_q <= is_last && head.has_tail && head.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			pos_q <= 3'd0;
		end else begin
			if (adv) begin
				ov_q  <= 1'b1;
				pos_q <= is_last ? 3'd0 : pos_q + 3'd1;
			end else if (mbox.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign mbox.valid        = ov_q;
	assign mbox.out_byte     = byte_q;
	assign mbox.last_of_run  = last_q;
	assign mbox.message_done = done_q;

endmodule

// ===== src/mbfe_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the mbox From-line escaper and its bind to the top level.
module mbfe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       last_of_run,
	input logic       message_done
);
	import mbfe_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Output transaction was withdrawn while stalled.");

	a_done_is_newline: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_done |-> last_of_run && (out_byte == CH_NL))
		else $error("Message end marker is not on a closing newline.");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid)
		else $error("A run broke off before its last byte.");

	a_gt_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (out_byte == CH_GT) && !last_of_run
		|=> out_byte == CH_F)
		else $error("A quote mark inside a run is not followed by From.");

endmodule

bind mbox_from_line_escaper mbfe_checker u_mbfe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (mbox.valid),
	.out_ready    (mbox.ready),
	.out_byte     (mbox.out_byte),
	.last_of_run  (mbox.last_of_run),
	.message_done (mbox.message_done)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for mbox_from_line_escaper: directed table, then randomized mail lines.
module tb_top;

	import mbfe_pkg::*;

	localparam int DIRECTED_ROWS = 25;
	localparam int ITEM_TARGET   = 280;
	localparam int PHASE_ITEMS   = 45;
	localparam int HOLD_CYCLES   = 8;
	localparam int DRAIN_CYCLES  = 20;
	localparam int CYCLE_LIMIT   = 100000;

	localparam logic [7:0] FROM_STR [5] = '{CH_F, CH_R, CH_O, CH_M, CH_SPACE};

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       done;
	} mbox_beat_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic       pinned;
		logic [7:0] pin_ch;
		logic       pin_done;
	} stim_row_t;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{KIND_DATA, 8'h78,    1'b1, 8'h78, 1'b0},
		'{KIND_DATA, 8'hFF,    1'b1, 8'hFF, 1'b0},
		'{KIND_DATA, 8'h00,    1'b1, 8'h00, 1'b0},
		'{KIND_DATA, CH_NL,    1'b1, CH_NL, 1'b0},
		'{KIND_DATA, CH_F,     1'b0, 8'h00, 1'b0},
		'{KIND_DATA, CH_R,     1'b0, 8'h00, 1'b0},
		'{KIND_DATA, CH_O,     1'b0, 8'h00, 1'b0},
		'{KIND_DATA, CH_M,     1'b0, 8'h00, 1'b0},
		'{KIND_DATA, CH_SPACE, 1'b0, 8'h00, 1'b0},
		'{KIND_DATA, 8'h61,    1'b1, 8'h61, 1'b0},
		'{KIND_DATA, CH_NL,    1'b1, CH_NL, 1'b0},
		'{KIND_DATA, CH_F,     1'b0, 8'h00, 1'b0},
		'{KIND_DATA, CH_R,     1'b0, 8'h00, 1'b0},
		'{KIND_DATA, 8'h58,    1'b0, 8'h00, 1'b0},
		'{KIND_DATA, CH_NL,    1'b1, CH_NL, 1'b0},
		'{KIND_DATA, CH_F,     1'b0, 8'h00, 1'b0},
		'{KIND_DATA, CH_R,     1'b0, 8'h00, 1'b0},
		'{KIND_DATA, CH_O,     1'b0, 8'h00, 1'b0},
		'{KIND_DATA, CH_M,     1'b0, 8'h00, 1'b0},
		'{KIND_EOM,  8'h00,    1'b0, 8'h00, 1'b0},
		'{KIND_EOM,  8'hFF,    1'b1, CH_NL, 1'b1},
		'{KIND_DATA, CH_F,     1'b0, 8'h00, 1'b0},
		'{KIND_DATA, CH_NL,    1'b0, 8'h00, 1'b0},
		'{KIND_DATA, CH_F,     1'b0, 8'h00, 1'b0},
		'{KIND_DATA, CH_R,     1'b0, 8'h00, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;
	logic sink_ready = 1'b0;
	logic [7:0] ready_phase = 8'd0;

	mbfe_msg_if  msg_ch();
	mbfe_mbox_if mbox_ch();

	assign mbox_ch.ready = sink_ready;

	mbox_from_line_escaper u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.msg         (msg_ch),
		.mbox        (mbox_ch)
	);

	// Predictor state.
	logic pm_escape;
	logic pm_line_start;
	int   pm_held;

	mbox_beat_t quoted_run[$];
	mbox_beat_t pending_bytes[$];
	mbox_beat_t want;

	int burst_left;
	int items_sent;
	int eom_sent;
	int from_quoted;
	int cfg_writes;
	int beats_seen;
	int mismatches;
	int cycle_count;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		ready_phase <= ready_phase + 8'd1;
		case (ready_phase[7:6])
			2'd0: sink_ready <= 1'b1;
			2'd1: sink_ready <= ($urandom_range(0, 2) != 0);
			2'd2: sink_ready <= (ready_phase[1:0] == 2'd0);
			default: sink_ready <= 1'($urandom_range(0, 1));
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d bytes still expected",
				cycle_count, pending_bytes.size());
			$display("mbox_from_line_escaper verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && mbox_ch.valid && mbox_ch.ready) begin
			beats_seen++;
			if (pending_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected mailbox byte %h last=%b done=%b",
						mbox_ch.out_byte, mbox_ch.last_of_run, mbox_ch.message_done);
			end else begin
				want = pending_bytes.pop_front();
				if (mbox_ch.out_byte !== want.ch || mbox_ch.last_of_run !== want.last ||
						mbox_ch.message_done !== want.done) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: byte %h last=%b done=%b, expected %h last=%b done=%b",
							mbox_ch.out_byte, mbox_ch.last_of_run, mbox_ch.message_done,
							want.ch, want.last, want.done);
				end
			end
		end
	end

	function automatic void emit(input logic [7:0] ch, input logic done);
		quoted_run.push_back('{ch: ch, last: 1'b0, done: done});
	endfunction

	function automatic void flush_held();
		int i;
		for (i = 0; i < pm_held; i++)
			emit(FROM_STR[i], 1'b0);
		pm_held = 0;
	endfunction

	// Computes the run of mailbox bytes that one message transaction produces.
	function automatic void quote_item(input logic k, input logic [7:0] b);
		int i;
		quoted_run.delete();
		if (k == KIND_EOM) begin
			flush_held();
			if (pm_escape)
				emit(CH_NL, 1'b1);
			pm_line_start = 1'b1;
		end else if (!pm_escape) begin
			flush_held();
			emit(b, 1'b0);
			pm_line_start = (b == CH_NL);
		end else if (pm_line_start && b == FROM_STR[pm_held]) begin
			pm_held++;
			if (pm_held == PFX_LEN) begin
				emit(CH_GT, 1'b0);
				for (i = 0; i < PFX_LEN; i++)
					emit(FROM_STR[i], 1'b0);
				pm_held = 0;
				pm_line_start = 1'b0;
				from_quoted++;
			end
		end else begin
			flush_held();
			emit(b, 1'b0);
			pm_line_start = (b == CH_NL);
		end
		if (quoted_run.size() > 0)
			quoted_run[quoted_run.size() - 1].last = 1'b1;
	endfunction

	function automatic logic [7:0] rand_char();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(32, 126));
	endfunction

	task automatic send_item(input logic k, input logic [7:0] d);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap != 0) begin
				msg_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) :
				$urandom_range(1, 8);
		end
		burst_left--;
		msg_ch.valid <= 1'b1;
		msg_ch.kind <= k;
		msg_ch.data_byte <= d;
		do @(posedge clk); while (!msg_ch.ready);
		quote_item(k, d);
		foreach (quoted_run[i])
			pending_bytes.push_back(quoted_run[i]);
		items_sent++;
		if (k == KIND_EOM)
			eom_sent++;
	endtask

	task automatic send_text(input int n);
		int i;
		for (i = 0; i < n; i++)
			send_item(KIND_DATA, rand_char());
	endtask

	task automatic send_prefix(input int n);
		int i;
		for (i = 0; i < n; i++)
			send_item(KIND_DATA, FROM_STR[i]);
	endtask

	task automatic send_line();
		int shape;
		int k;
		logic [7:0] b;
		shape = $urandom_range(0, 10);
		k = $urandom_range(1, 4);
		case (shape)
			0, 1, 2: begin
				send_prefix(PFX_LEN);
				send_text($urandom_range(0, 6));
				send_item(KIND_DATA, CH_NL);
			end
			3, 4: begin
				send_prefix(k);
				do b = rand_char(); while (b == FROM_STR[k] || b == CH_NL);
				send_item(KIND_DATA, b);
				send_text($urandom_range(0, 4));
				send_item(KIND_DATA, CH_NL);
			end
			5: begin
				send_prefix(k);
				send_item(KIND_DATA, CH_NL);
			end
			6: begin
				send_prefix(k);
				send_item(KIND_EOM, rand_char());
			end
			7: begin
				send_text($urandom_range(1, 8));
				send_item(KIND_DATA, CH_NL);
			end
			8: send_item(KIND_EOM, 8'($urandom_range(0, 255)));
			9: send_prefix(k);
			default: begin
				send_text($urandom_range(1, 3));
				send_prefix(PFX_LEN);
				send_item(KIND_DATA, CH_NL);
			end
		endcase
	endtask

	task automatic set_escape(input logic v);
		do @(posedge clk); while (pending_bytes.size() != 0);
		repeat (HOLD_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		pm_escape = v;
		cfg_writes++;
	endtask

	initial begin
		logic next_escape;
		int phase_end;
		int copy_phases;
		bit paused;
		msg_ch.valid = 1'b0;
		msg_ch.kind = KIND_DATA;
		msg_ch.data_byte = 8'h00;
		pm_escape = 1'b1;
		pm_line_start = 1'b1;
		pm_held = 0;
		burst_left = 0;
		items_sent = 0;
		eom_sent = 0;
		from_quoted = 0;
		cfg_writes = 0;
		beats_seen = 0;
		mismatches = 0;
		cycle_count = 0;
		next_escape = 1'b0;
		copy_phases = 0;
		paused = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			send_item(directed_rows[r].kind, directed_rows[r].data);
			if (directed_rows[r].pinned) begin
				repeat (quoted_run.size()) void'(pending_bytes.pop_back());
				pending_bytes.push_back('{ch: directed_rows[r].pin_ch, last: 1'b1,
					done: directed_rows[r].pin_done});
			end
		end
		msg_ch.valid <= 1'b0;
		burst_left = 0;

		while (items_sent < ITEM_TARGET) begin
			set_escape(next_escape);
			// Every other copy phase opens with an end of message while prefix bytes are held.
			if (!next_escape) begin
				if (copy_phases % 2 == 0)
					send_item(KIND_EOM, rand_char());
				copy_phases++;
			end
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
				send_line();
				if (!paused && items_sent > DIRECTED_ROWS + 100) begin
					msg_ch.valid <= 1'b0;
					burst_left = 0;
					do @(posedge clk); while (pending_bytes.size() != 0);
					paused = 1'b1;
				end
			end
			send_item(KIND_DATA, CH_NL);
			send_prefix($urandom_range(1, 4));
			msg_ch.valid <= 1'b0;
			burst_left = 0;
			next_escape = !next_escape;
		end

		do @(posedge clk); while (pending_bytes.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d message transactions (%0d end of message) over %0d mode changes.",
			items_sent, eom_sent, cfg_writes);
		$display("Checked %0d mailbox bytes including %0d quoted From lines; %0d mismatches.",
			beats_seen, from_quoted, mismatches);
		if (mismatches == 0 && pending_bytes.size() == 0) begin
			$display("mbox_from_line_escaper verification clean");
		end else begin
			$display("mbox_from_line_escaper verification failed");
		end
		$finish;
	end

endmodule
